### src/cbp_pkg.sv
// ----------------------------------------------------------------------------
// Block cipher padder package
// Shared constants, configuration codes and controller/datapath structs.
// ----------------------------------------------------------------------------
`default_nettype none

package cbp_pkg;

  // Largest cipher block that the padder handles, in bytes.
  localparam int unsigned MaxBlock   = 32;
  // Block size that PKCS#5 demands.
  localparam int unsigned Pkcs5Block = 8;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned SizeW  = 6;                   // block_size register
  localparam int unsigned PosW   = $clog2(MaxBlock);    // position within block
  localparam int unsigned CntW   = $clog2(MaxBlock + 1); // pad byte count
  localparam int unsigned CfgIdxW = 1;
  localparam int unsigned CfgDatW = SizeW;

  typedef enum logic [1:0] {
    SchemeZero  = 2'd0,
    SchemeX923  = 2'd1,
    SchemePkcs5 = 2'd2,
    SchemePkcs7 = 2'd3
  } pad_scheme_e;

  typedef enum logic [CfgIdxW-1:0] {
    RegPadScheme = 1'b0,
    RegBlockSize = 1'b1
  } cfg_reg_e;

  localparam pad_scheme_e SchemeReset    = SchemePkcs7;
  localparam logic [SizeW-1:0] SizeReset = SizeW'(16);

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;  // an input transaction completes this cycle
    logic send_pad;   // load the next pad byte into the output register
  } cbp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pad_needed; // the offered item ends a message that gets pad bytes
    logic pad_last;   // the next pad byte is the final one
    logic out_full;   // the output register holds an untaken result
  } cbp_sts_t;

endpackage

`default_nettype wire

### src/cbp_if.sv
// ----------------------------------------------------------------------------
// Block cipher padder channel interfaces
// Input byte stream, result stream and configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface cbp_in_if;
  logic                      valid;
  logic                      ready;
  logic [cbp_pkg::ByteW-1:0] data_byte;
  logic                      is_last;
  logic                      no_byte;

  modport source (output valid, data_byte, is_last, no_byte, input ready);
  modport sink   (input valid, data_byte, is_last, no_byte, output ready);
endinterface

interface cbp_out_if;
  logic                      valid;
  logic                      ready;
  logic [cbp_pkg::ByteW-1:0] out_byte;
  logic                      out_last;
  logic                      setup_error;

  modport source (output valid, out_byte, out_last, setup_error, input ready);
  modport sink   (input valid, out_byte, out_last, setup_error, output ready);
endinterface

interface cbp_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cbp_pkg::CfgIdxW-1:0] index;
  logic [cbp_pkg::CfgDatW-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

### src/cbp_ctrl.sv
// ----------------------------------------------------------------------------
// Block cipher padder controller
// Two-state machine: pass message bytes, then emit the pad run.
// ----------------------------------------------------------------------------
`default_nettype none

module cbp_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic              out_ready_i,
  input  wire cbp_pkg::cbp_sts_t sts_i,
  output cbp_pkg::cbp_cmd_t      cmd_o
);
  import cbp_pkg::*;

  localparam logic StIdle = 1'b0;
  localparam logic StPad  = 1'b1;

  logic state_q, state_d;
  logic slot_free;

  // The output register can take a new result when empty or being drained.
  assign slot_free = !sts_i.out_full || out_ready_i;

  always_comb begin
    state_d          = state_q;
    in_ready_o       = 1'b0;
    cmd_o.take_item  = 1'b0;
    cmd_o.send_pad   = 1'b0;
    case (state_q)
      StIdle: begin
        in_ready_o      = slot_free;
        cmd_o.take_item = in_valid_i && slot_free;
        if (cmd_o.take_item && sts_i.pad_needed) begin
          state_d = StPad;
        end
      end
      StPad: begin
        cmd_o.send_pad = slot_free;
        if (slot_free && sts_i.pad_last) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

### src/cbp_dpath.sv
// ----------------------------------------------------------------------------
// Block cipher padder datapath
// Configuration registers, block position, pad counter and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cbp_dpath (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [cbp_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [cbp_pkg::CfgDatW-1:0] cfg_data_i,
  input  wire logic [cbp_pkg::ByteW-1:0]   data_byte_i,
  input  wire logic                        is_last_i,
  input  wire logic                        no_byte_i,
  input  wire logic                        out_ready_i,
  input  wire cbp_pkg::cbp_cmd_t           cmd_i,
  output cbp_pkg::cbp_sts_t                sts_o,
  output logic                             out_valid_o,
  output logic [cbp_pkg::ByteW-1:0]        out_byte_o,
  output logic                             out_last_o,
  output logic                             setup_error_o
);
  import cbp_pkg::*;

  pad_scheme_e      scheme_q;
  logic [SizeW-1:0] size_q;
  logic [PosW-1:0]  pos_q, pos_d, pos_next;
  logic [CntW-1:0]  pad_cnt_q, pad_cnt_d;
  logic [CntW-1:0]  pad_val_q, pad_val_d;
  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] out_byte_q, out_byte_d;
  logic             out_last_q, out_last_d;
  logic             out_err_q, out_err_d;

  logic             size_ok, setup_err;
  logic [SizeW-1:0] pos_inc;
  logic [PosW-1:0]  rem;
  logic [CntW-1:0]  count;

  assign size_ok   = (size_q >= SizeW'(1)) && (size_q <= SizeW'(MaxBlock));
  assign setup_err = !size_ok || ((scheme_q == SchemePkcs5) &&
                                  (size_q != SizeW'(Pkcs5Block)));

  // Position after the offered byte, and the partial-block remainder.
  assign pos_inc = {1'b0, pos_q} + SizeW'(1);

  always_comb begin
    if (no_byte_i) begin
      pos_next = pos_q;
    end else if (!size_ok || pos_inc >= size_q) begin
      pos_next = '0;
    end else begin
      pos_next = pos_inc[PosW-1:0];
    end
    rem = (size_ok && ({1'b0, pos_next} < size_q)) ? pos_next : '0;
  end

  // Number of pad bytes for a message ending with the offered item.
  always_comb begin
    count = '0;
    if (!setup_err) begin
      case (scheme_q)
        SchemeZero:  count = (rem == '0) ? '0 : CntW'(size_q - {1'b0, rem});
        SchemePkcs5: count = CntW'(Pkcs5Block) - CntW'(rem);
        default:     count = CntW'(size_q - {1'b0, rem});
      endcase
    end
  end

  assign sts_o.pad_needed = is_last_i && (count != '0);
  assign sts_o.pad_last   = (pad_cnt_q == CntW'(1));
  assign sts_o.out_full   = out_valid_q;

  always_comb begin
    pos_d       = pos_q;
    pad_cnt_d   = pad_cnt_q;
    pad_val_d   = pad_val_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    out_last_d  = out_last_q;
    out_err_d   = out_err_q;
    if (cmd_i.take_item) begin
      pos_d       = is_last_i ? '0 : pos_next;
      pad_cnt_d   = count;
      // Zero fill pads with zeros only; the other schemes carry the count.
      pad_val_d   = (scheme_q == SchemeZero) ? '0 : count;
      out_valid_d = !no_byte_i;
      out_byte_d  = data_byte_i;
      out_last_d  = is_last_i && (count == '0);
      out_err_d   = setup_err;
    end else if (cmd_i.send_pad) begin
      pad_cnt_d   = pad_cnt_q - CntW'(1);
      out_valid_d = 1'b1;
      // X9.23 fills with zeros and puts the count only in the final byte.
      if ((scheme_q == SchemeX923) && !sts_o.pad_last) begin
        out_byte_d = '0;
      end else begin
        out_byte_d = ByteW'(pad_val_q);
      end
      out_last_d  = sts_o.pad_last;
      out_err_d   = 1'b0;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scheme_q    <= SchemeReset;
      size_q      <= SizeReset;
      pos_q       <= '0;
      pad_cnt_q   <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          RegPadScheme: scheme_q <= pad_scheme_e'(cfg_data_i[1:0]);
          RegBlockSize: size_q   <= cfg_data_i;
          default: ;
        endcase
      end
      pos_q       <= pos_d;
      pad_cnt_q   <= pad_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pad_val_q  <= pad_val_d;
    out_byte_q <= out_byte_d;
    out_last_q <= out_last_d;
    out_err_q  <= out_err_d;
  end

  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign out_last_o    = out_last_q;
  assign setup_error_o = out_err_q;

endmodule

`default_nettype wire

### src/block_cipher_padder_core.sv
// ----------------------------------------------------------------------------
// Block cipher padder
// Passes message bytes through and appends zero, X9.23, PKCS#5 or PKCS#7
// padding at the end of each message.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Transaction carries
//   byte_in   sink       data_byte, is_last, no_byte
//   byte_out  source     out_byte, out_last, setup_error
//   cfg_in    sink       index (0 pad_scheme, 1 block_size), data
//
// A message byte that is taken appears on byte_out in the next cycle;
// with byte_out ready, bytes flow at one transaction per cycle.
// An end mark that needs padding is followed by up to 32 pad-counter bytes,
// one per cycle while byte_out is ready; byte_in.ready stays low throughout.
// The result sits in a single output register, so a stalled byte_out holds
// its transaction and byte_in waits until that register can be reloaded.
// rst_ni clears the block position, the output register and the controller,
// and restores PKCS#7 with a 16-byte block. Configuration writes are always
// accepted and are meant for times when no message is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module block_cipher_padder_core (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  cbp_in_if.sink    byte_in,
  cbp_out_if.source byte_out,
  cbp_cfg_if.sink   cfg_in
);
  import cbp_pkg::*;

  cbp_cmd_t cmd;
  cbp_sts_t sts;

  // Configuration registers are simple flops, so a write never stalls.
  assign cfg_in.ready = 1'b1;

  // The controller sequences transactions: it accepts message items while
  // the output register can be reloaded, then steps through the pad run.
  cbp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (byte_in.valid),
    .in_ready_o  (byte_in.ready),
    .out_ready_i (byte_out.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // The datapath works out the block position, the pad length and value,
  // and holds the result register that drives byte_out.
  cbp_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_in.valid),
    .cfg_index_i   (cfg_in.index),
    .cfg_data_i    (cfg_in.data),
    .data_byte_i   (byte_in.data_byte),
    .is_last_i     (byte_in.is_last),
    .no_byte_i     (byte_in.no_byte),
    .out_ready_i   (byte_out.ready),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .out_valid_o   (byte_out.valid),
    .out_byte_o    (byte_out.out_byte),
    .out_last_o    (byte_out.out_last),
    .setup_error_o (byte_out.setup_error)
  );

  // An input item is never taken in a cycle that loads a pad byte.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(cmd.take_item && cmd.send_pad))
    else $error("input taken while a pad byte is loaded");

  // Loading the final pad byte presents a transaction flagged as last.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.send_pad && sts.pad_last |=> byte_out.valid && byte_out.out_last)
    else $error("final pad byte not flagged as last");

  // Once an end mark starts a pad run, byte_in.ready is low as the run begins.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.take_item && sts.pad_needed |=> !byte_in.ready)
    else $error("input accepted at the start of a pad run");

endmodule

`default_nettype wire
